[hw/rtl/ipd_pkg.sv]
// Shared types and constants for the IR pulse-distance decoder.
// Used by every module of the block; depends on nothing else.
package ipd_pkg;

	// Default widths of the code register and the interval tick counter.
	localparam int CODE_BITS_DEF = 8;
	localparam int TICK_BITS_DEF = 24;

	// Fixed widths of the register fields and of the delivered code byte.
	localparam int IDX_W     = 6;
	localparam int THR_W     = 24;
	localparam int CODE_OUT_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_INTERVALS  = 3'd0,
		REG_DATA_FIRST_INDEX = 3'd1,
		REG_DATA_END_INDEX   = 3'd2,
		REG_ONE_THRESHOLD    = 3'd3,
		REG_TIMEOUT_TICKS    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0] frame_intervals;
		logic [IDX_W-1:0] data_first_index;
		logic [IDX_W-1:0] data_end_index;
		logic [THR_W-1:0] one_threshold;
		logic [THR_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic ir_fall;
		logic release_req;
	} in_item_t;

	typedef struct packed {
		logic                  code_ready;
		logic [CODE_OUT_W-1:0] code;
		logic                  receiving;
	} out_item_t;

endpackage

[hw/rtl/ipd_cfg_regs.sv]
// Configuration register file of the IR pulse-distance decoder.
// Depends on ipd_pkg for the register indexes and the cfg_t struct.
module ipd_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [ipd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ipd_pkg::CFG_DATA_W-1:0] wr_data,
	output ipd_pkg::cfg_t              cfg
);
	import ipd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_intervals  <= IDX_W'(33);
			cfg_q.data_first_index <= IDX_W'(17);
			cfg_q.data_end_index   <= IDX_W'(25);
			cfg_q.one_threshold    <= THR_W'(2000);
			cfg_q.timeout_ticks    <= THR_W'(1000000);
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_FRAME_INTERVALS:  cfg_q.frame_intervals  <= wr_data[IDX_W-1:0];
				REG_DATA_FIRST_INDEX: cfg_q.data_first_index <= wr_data[IDX_W-1:0];
				REG_DATA_END_INDEX:   cfg_q.data_end_index   <= wr_data[IDX_W-1:0];
				REG_ONE_THRESHOLD:    cfg_q.one_threshold    <= wr_data[THR_W-1:0];
				REG_TIMEOUT_TICKS:    cfg_q.timeout_ticks    <= wr_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/ipd_frame_fsm.sv]
// Frame state machine: interval counter, edge classification and code assembly.
// Depends on ipd_pkg; one tick is applied per cycle when advance is high.
module ipd_frame_fsm #(
	parameter int CODE_BITS = ipd_pkg::CODE_BITS_DEF,
	parameter int TICK_BITS = ipd_pkg::TICK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  ipd_pkg::in_item_t    item,
	input  ipd_pkg::cfg_t        cfg,
	output ipd_pkg::out_item_t   result
);
	import ipd_pkg::*;

	// Compare width wide enough for both the tick counter and 24-bit registers.
	localparam int CMP_W = (TICK_BITS > THR_W) ? TICK_BITS : THR_W;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_TIMING = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [TICK_BITS-1:0]   ticks_q, ticks_d, ticks_inc;
	logic [IDX_W-1:0]       edges_q, edges_d, edges_inc, bit_pos;
	logic [CODE_BITS-1:0]   code_q, code_d;
	logic                   in_window, is_one;

	assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + TICK_BITS'(1);
	assign edges_inc = edges_q + IDX_W'(1);
	assign bit_pos   = edges_q - cfg.data_first_index;
	assign in_window = (edges_q >= cfg.data_first_index) &&
	                   (edges_q < cfg.data_end_index) &&
	                   ({1'b0, bit_pos} < (IDX_W+1)'(CODE_BITS));
	assign is_one    = CMP_W'(ticks_inc) >= CMP_W'(cfg.one_threshold);

	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		edges_d = edges_q;
		code_d  = code_q;
		case (phase_q)
			PH_DONE: begin
				// Edges are ignored while a code is held.
				if (item.release_req) begin
					phase_d = PH_IDLE;
					ticks_d = '0;
					edges_d = '0;
					code_d  = '0;
				end
			end
			PH_TIMING: begin
				if (item.ir_fall) begin
					ticks_d = '0;
					edges_d = edges_inc;
					if (in_window && is_one) begin
						code_d = code_q | (CODE_BITS'(1) << bit_pos);
					end
					if (edges_inc == cfg.frame_intervals) begin
						phase_d = PH_DONE;
					end
				end else if (CMP_W'(ticks_inc) >= CMP_W'(cfg.timeout_ticks)) begin
					phase_d = PH_IDLE;
					ticks_d = '0;
					edges_d = '0;
					code_d  = '0;
				end else begin
					ticks_d = ticks_inc;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (item.ir_fall) begin
					phase_d = PH_TIMING;
					ticks_d = '0;
					edges_d = '0;
					code_d  = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			edges_q <= '0;
			code_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			edges_q <= edges_d;
			code_q  <= code_d;
		end
	end

	// The result shows the state after this tick.
	always_comb begin
		result.code_ready = (phase_d == PH_DONE);
		result.code       = (phase_d == PH_DONE) ? CODE_OUT_W'(code_d) : '0;
		result.receiving  = (phase_d == PH_TIMING);
	end

endmodule

[hw/rtl/ir_pulse_distance_decoder_core.sv]
// IR pulse-distance decoder: one input transfer per timer tick, one result per tick.
// Each accepted tick is decoded combinationally and lands in an output register;
// a new tick is taken every cycle while the result is consumed, so the block runs
// at one tick per clock. Result valid rises in the cycle after the input transfer.
// Configuration writes are taken in any cycle and apply from the next tick on.
// Depends on ipd_pkg, ipd_cfg_regs and ipd_frame_fsm.
module ir_pulse_distance_decoder_core #(
	parameter int CODE_BITS = ipd_pkg::CODE_BITS_DEF,
	parameter int TICK_BITS = ipd_pkg::TICK_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ipd_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ipd_pkg::out_item_t             out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ipd_pkg::*;

	cfg_t      cfg;
	out_item_t result;
	out_item_t out_data_q;
	logic      out_valid_q;
	logic      in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	ipd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ipd_frame_fsm #(
		.CODE_BITS (CODE_BITS),
		.TICK_BITS (TICK_BITS)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (in_fire),
		.item    (in_data),
		.cfg     (cfg),
		.result  (result)
	);

	// Output register; it refills in the same cycle its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
